/* sv/pgc_pkg.sv */
// ----------------------------------------------------------------------------
// pgc_pkg
// Types, latency and elaboration-time tables for the gamma correction core.
// ----------------------------------------------------------------------------
`default_nettype none

package pgc_pkg;

	localparam int LogFrac  = 20;
	localparam int ExpSteps = 20;
	// d table, product, exp steps, final scale
	localparam int Latency  = ExpSteps + 3;

	typedef struct packed {
		logic [7:0] channel_0;
		logic [7:0] channel_1;
		logic [7:0] channel_2;
		logic       three_channels;
	} pgc_in_t;

	typedef struct packed {
		logic [7:0] result_0;
		logic [7:0] result_1;
		logic [7:0] result_2;
	} pgc_out_t;

	typedef logic [255:0][22:0]      dtab_t;
	typedef logic [ExpSteps:1][29:0] ctab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
		logic [63:0] a;
		logic [63:0] r;
		logic [63:0] b;
		a = a_in;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > a) b = b >> 2;
		while (b != 64'd0) begin
			if (a >= r + b) begin
				a = a - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [22:0] log2_q20(input int x);
		int          e;
		logic [63:0] m;
		logic [22:0] frac;
		e = 0;
		while (e < 7 && (x >> (e + 1)) != 0) e++;
		m = 64'(x) << (30 - e);
		frac = 23'd0;
		for (int i = 0; i < LogFrac; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 23'd1;
				m = m >> 1;
			end
		end
		return (23'(e) << LogFrac) | frac;
	endfunction

	// log2(255) - log2(x), Q20; entry 0 unused
	function automatic dtab_t build_dtab();
		dtab_t t;
		logic [22:0] top;
		top = log2_q20(255);
		t[0] = 23'd0;
		for (int x = 1; x < 256; x++) t[x] = top - log2_q20(x);
		return t;
	endfunction

	// c_k = 2^(-2^-k) in Q30
	function automatic ctab_t build_ctab();
		ctab_t       t;
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int k = 1; k <= ExpSteps; k++) begin
			t[k] = c[29:0];
			c = isqrt64(c << 30);
		end
		return t;
	endfunction

	localparam dtab_t DTAB = build_dtab();
	localparam ctab_t CTAB = build_ctab();

endpackage

`default_nettype wire

/* sv/pgc_lane.sv */
// ----------------------------------------------------------------------------
// pgc_lane
// One channel: table log step, product with exponent, 20-stage exp2 chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pgc_lane
	import pgc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [7:0]  x,
	input  wire logic [15:0] r,
	output logic [7:0]       y
);

	logic [22:0] d_s1;
	logic        zero_s1;
	logic [38:0] prod;

	logic [30:0] v_sn    [0:ExpSteps];
	logic [19:0] fb_sn   [0:ExpSteps];
	logic [2:0]  sh_sn   [0:ExpSteps];
	logic        kill_sn [0:ExpSteps];

	logic [30:0] vs;
	logic [38:0] t;
	logic [7:0]  y_sf;

	always_ff @(posedge clk) begin
		d_s1    <= DTAB[x];
		zero_s1 <= (x == 8'd0);
	end

	assign prod = 39'(d_s1) * 39'(r);

	// exponent integer part of 8 or more underflows to zero
	always_ff @(posedge clk) begin
		v_sn[0]    <= 31'd1 << 30;
		fb_sn[0]   <= prod[31:12];
		sh_sn[0]   <= prod[34:32];
		kill_sn[0] <= zero_s1 | (prod[38:35] != 4'd0);
	end

	for (genvar k = 1; k <= ExpSteps; k++) begin : g_exp
		logic [60:0] mul;
		assign mul = 61'(v_sn[k-1]) * 61'(CTAB[k]);
		always_ff @(posedge clk) begin
			v_sn[k]    <= fb_sn[k-1][ExpSteps-k] ? mul[60:30] : v_sn[k-1];
			fb_sn[k]   <= fb_sn[k-1];
			sh_sn[k]   <= sh_sn[k-1];
			kill_sn[k] <= kill_sn[k-1];
		end
	end

	assign vs = v_sn[ExpSteps] >> sh_sn[ExpSteps];
	assign t  = {vs, 8'd0} - 39'(vs);

	always_ff @(posedge clk) begin
		if (kill_sn[ExpSteps]) begin
			y_sf <= 8'd0;
		end else if (t[38:30] > 9'd255) begin
			y_sf <= 8'd255;
		end else begin
			y_sf <= t[37:30];
		end
	end

	assign y = y_sf;

endmodule

`default_nettype wire

/* sv/pixel_gamma_correction_core.sv */
// ----------------------------------------------------------------------------
// pixel_gamma_correction_core
// Power-law gamma correction of one pixel of up to three 8-bit channels.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel word is taken at each clock edge with start high; busy is always
//   low, so one pixel per clock is accepted without gaps.
//   Each result word appears on result for one cycle with strobe high,
//   after the pipeline stages in order: the log table register, the
//   product with the exponent, one register per exp2 factor multiply (20)
//   and final scaling. Throughput is one word per clock, set by the three
//   channel lanes whose pipelines advance every cycle.
//   gamma_we/gamma_wdata write the exponent (unsigned Q4.12); write it only
//   while no pixel is in flight.
//   Reset clears the in-flight marks and sets the exponent to 1.0 (4096).
//   The receiver cannot stall: each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_gamma_correction_core
	import pgc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire pgc_in_t     pixel,
	output logic             strobe,
	output pgc_out_t         result,
	input  wire logic        gamma_we,
	input  wire logic [15:0] gamma_wdata
);

	logic [15:0]  gr_q;
	logic [Latency-1:0] vld_q;
	pgc_in_t      raw_q [0:Latency-1];
	logic [7:0]   y0, y1, y2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gr_q  <= 16'd4096;
			vld_q <= '0;
		end else begin
			if (gamma_we) gr_q <= gamma_wdata;
			vld_q <= {vld_q[Latency-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		raw_q[0] <= pixel;
		for (int i = 1; i < Latency; i++) raw_q[i] <= raw_q[i-1];
	end

	pgc_lane u_lane0 (.clk(clk), .x(pixel.channel_0), .r(gr_q), .y(y0));
	pgc_lane u_lane1 (.clk(clk), .x(pixel.channel_1), .r(gr_q), .y(y1));
	pgc_lane u_lane2 (.clk(clk), .x(pixel.channel_2), .r(gr_q), .y(y2));

	// merge: single-channel words pass channels 1 and 2 through
	always_comb begin
		result.result_0 = y0;
		if (raw_q[Latency-1].three_channels) begin
			result.result_1 = y1;
			result.result_2 = y2;
		end else begin
			result.result_1 = raw_q[Latency-1].channel_1;
			result.result_2 = raw_q[Latency-1].channel_2;
		end
	end

	assign strobe = vld_q[Latency-1];

endmodule

`default_nettype wire
